// ===== rtl/core/esc_pkg.sv =====
`timescale 1ns / 1ps

package esc_pkg;

  localparam int CFG_W  = 64;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_PRESS_C = 3'd3,
    CFG_HUM_A   = 3'd4,
    CFG_HUM_B   = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] FUNC_TEMP   = 2'd0;
  localparam logic [1:0] FUNC_PRESS  = 2'd1;
  localparam logic [1:0] FUNC_HUM    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] raw_reading;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        div_zero;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TA, ST_TB, ST_TC,
    ST_PA, ST_PB, ST_PC, ST_PD, ST_PE, ST_PF, ST_PG, ST_PDIV, ST_PI, ST_PJ, ST_PK,
    ST_HA, ST_HB, ST_HC, ST_HD, ST_HE, ST_HF, ST_HG, ST_HH,
    ST_DONE
  } state_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
    return 64'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

// ===== rtl/core/esc_mul64.sv =====
`timescale 1ns / 1ps

// 64 x 64 product, low 64 bits, from one 32 x 32 multiplier over three partial products
module esc_mul64
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic [2:0]  phase_r;
  logic [63:0] a_r, b_r, pp_r, acc_r;
  logic        done_r;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    unique case (phase_r)
      3'd2:    begin ma = a_r[31:0];  mb = b_r[63:32]; end
      3'd3:    begin ma = a_r[63:32]; mb = b_r[31:0];  end
      default: begin ma = a_r[31:0];  mb = b_r[31:0];  end
    endcase
  end

  assign prod = {32'b0, ma} * {32'b0, mb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        3'd0: if (start) phase_r <= 3'd1;
        3'd4: begin
          phase_r <= 3'd0;
          done_r  <= 1'b1;
        end
        default: phase_r <= phase_r + 3'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == 3'd0 && start) begin
      a_r <= a;
      b_r <= b;
    end
    unique case (phase_r)
      3'd1: pp_r <= prod;
      3'd2: begin
        acc_r <= pp_r;
        pp_r  <= prod;
      end
      3'd3: begin
        acc_r <= acc_r + {pp_r[31:0], 32'b0};
        pp_r  <= prod;
      end
      3'd4: acc_r <= acc_r + {pp_r[31:0], 32'b0};
      default: ;
    endcase
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== rtl/core/esc_div64.sv =====
`timescale 1ns / 1ps

// signed 64-bit division, one quotient bit per cycle, truncating toward zero
module esc_div64
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [6:0]  cnt_r;
  logic        busy_r, done_r, neg_r;
  logic [63:0] rem_r, q_r, d_r;
  logic [64:0] shifted, diff;

  assign shifted = {rem_r, q_r[63]};
  assign diff    = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      neg_r <= num[63] ^ den[63];
      q_r   <= num[63] ? 64'd0 - num : num;
      d_r   <= den[63] ? 64'd0 - den : den;
      rem_r <= 64'd0;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_r <= diff[63:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[63:0];
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? 64'd0 - q_r : q_r;

endmodule

// ===== rtl/core/env_sensor_compensation_top.sv =====
`timescale 1ns / 1ps

// Integer compensation of raw temperature, pressure and humidity readings.
// One item is taken at a time. A temperature item takes 3 multiply steps, a
// humidity item 8 steps and a pressure item 10 multiply steps plus one
// division; a pressure item with a zero divisor stops after 6 steps and an
// unused func code goes straight to the result with no step. Each multiply
// step runs on the shared four-phase 32x32 multiplier, and the division on
// the bit-serial divider. in_stall is high while an item is in work; a
// finished result waits in the output register, and a temperature item
// updates the stored fine temperature that later items use. Calibration
// registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while the block is idle, which the block does not enforce.
module env_sensor_compensation_top
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // calibration words
  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r, press_b_r;
  logic [15:0] press_c_r;
  logic [31:0] hum_a_r;
  logic [39:0] hum_b_r;
  logic [31:0] ft_r;

  state_t      state_r, state_nxt;
  logic        busy_r;
  logic [19:0] raw_r;
  logic [63:0] x_r, y_r, z_r, w_r;
  out_t        res_r;
  logic        out_valid_r;
  out_t        out_data_r;

  logic        in_xfer, step_done, out_free;
  logic        mul_start, mul_done, div_start, div_done, is_mul_step;
  logic [63:0] mul_a, mul_b, m, quot;
  logic [31:0] m32;

  // decoded coefficients
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {48'b0, temp_cal_r[15:0]};
  assign t2 = sx16(temp_cal_r[31:16]);
  assign t3 = sx16(temp_cal_r[47:32]);
  assign p1 = {48'b0, press_a_r[15:0]};
  assign p2 = sx16(press_a_r[31:16]);
  assign p3 = sx16(press_a_r[47:32]);
  assign p4 = sx16(press_a_r[63:48]);
  assign p5 = sx16(press_b_r[15:0]);
  assign p6 = sx16(press_b_r[31:16]);
  assign p7 = sx16(press_b_r[47:32]);
  assign p8 = sx16(press_b_r[63:48]);
  assign p9 = sx16(press_c_r);
  assign h1 = {56'b0, hum_a_r[7:0]};
  assign h2 = sx16(hum_a_r[23:8]);
  assign h3 = {56'b0, hum_a_r[31:24]};
  assign h4 = sx16(hum_b_r[15:0]);
  assign h5 = sx16(hum_b_r[31:16]);
  assign h6 = {{56{hum_b_r[39]}}, hum_b_r[39:32]};

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign m32       = m[31:0];
  assign step_done = busy_r && (mul_done || div_done);

  // shared arithmetic units
  esc_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (m)
  );

  esc_div64 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (x_r),
    .den   (y_r),
    .done  (div_done),
    .quot  (quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
      hum_a_r    <= '0;
      hum_b_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP:    temp_cal_r <= cfg_wdata[47:0];
        CFG_PRESS_A: press_a_r  <= cfg_wdata;
        CFG_PRESS_B: press_b_r  <= cfg_wdata;
        CFG_PRESS_C: press_c_r  <= cfg_wdata[15:0];
        CFG_HUM_A:   hum_a_r    <= cfg_wdata[31:0];
        CFG_HUM_B:   hum_b_r    <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) begin
        priority case (in_data.func)
          FUNC_TEMP:  state_nxt = ST_TA;
          FUNC_PRESS: state_nxt = ST_PA;
          FUNC_HUM:   state_nxt = ST_HA;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: if (step_done) begin
        unique case (state_r)
          ST_TA:   state_nxt = ST_TB;
          ST_TB:   state_nxt = ST_TC;
          ST_PA:   state_nxt = ST_PB;
          ST_PB:   state_nxt = ST_PC;
          ST_PC:   state_nxt = ST_PD;
          ST_PD:   state_nxt = ST_PE;
          ST_PE:   state_nxt = ST_PF;
          ST_PF:   state_nxt = (asr64(m, 33) == 64'd0) ? ST_DONE : ST_PG;
          ST_PG:   state_nxt = ST_PDIV;
          ST_PDIV: state_nxt = ST_PI;
          ST_PI:   state_nxt = ST_PJ;
          ST_PJ:   state_nxt = ST_PK;
          ST_HA:   state_nxt = ST_HB;
          ST_HB:   state_nxt = ST_HC;
          ST_HC:   state_nxt = ST_HD;
          ST_HD:   state_nxt = ST_HE;
          ST_HE:   state_nxt = ST_HF;
          ST_HF:   state_nxt = ST_HG;
          ST_HG:   state_nxt = ST_HH;
          default: state_nxt = ST_DONE;
        endcase
      end
    endcase
  end

  // multiplier operands and unit launches
  always_comb begin
    mul_a = x_r;
    mul_b = x_r;
    is_mul_step = 1'b1;
    unique case (state_r)
      ST_TA: begin
        mul_a = {32'b0, 32'(raw_r >> 3) - (t1[31:0] << 1)};
        mul_b = t2;
      end
      ST_TB: begin
        mul_a = {32'b0, 32'(raw_r >> 4) - t1[31:0]};
        mul_b = mul_a;
      end
      ST_TC: begin mul_a = y_r; mul_b = t3; end
      ST_PA: begin mul_a = x_r; mul_b = x_r; end
      ST_PB: begin mul_a = y_r; mul_b = p6; end
      ST_PC: begin mul_a = x_r; mul_b = p5; end
      ST_PD: begin mul_a = y_r; mul_b = p3; end
      ST_PE: begin mul_a = x_r; mul_b = p2; end
      ST_PF: begin mul_a = y_r + (64'd1 << 47); mul_b = p1; end
      ST_PG: begin
        mul_a = ((64'd1048576 - {44'b0, raw_r}) << 31) - z_r;
        mul_b = 64'd3125;
      end
      ST_PI: begin mul_a = p9;  mul_b = asr64(x_r, 13); end
      ST_PJ: begin mul_a = z_r; mul_b = asr64(x_r, 13); end
      ST_PK: begin mul_a = p8;  mul_b = x_r; end
      ST_HA: begin mul_a = h5;  mul_b = x_r; end
      ST_HB: begin mul_a = x_r; mul_b = h6; end
      ST_HC: begin mul_a = x_r; mul_b = h3; end
      ST_HD: begin mul_a = z_r; mul_b = w_r; end
      ST_HE: begin mul_a = z_r; mul_b = h2; end
      ST_HF: begin mul_a = y_r; mul_b = z_r; end
      ST_HG: begin
        mul_a = {32'b0, asr32(x_r[31:0], 15)};
        mul_b = mul_a;
      end
      ST_HH: begin mul_a = z_r; mul_b = h1; end
      default: is_mul_step = 1'b0;
    endcase
    mul_start = is_mul_step && !busy_r;
    div_start = (state_r == ST_PDIV) && !busy_r;
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ft_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_start || div_start) busy_r <= 1'b1;
      else if (step_done)         busy_r <= 1'b0;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_TC && step_done)
        ft_r <= x_r[31:0] + asr32(m32, 14);
    end
  end

  // datapath
  always_ff @(posedge clk) begin : dp
    logic [31:0] ftn, hv;
    ftn = x_r[31:0] + asr32(m32, 14);
    hv  = x_r[31:0] - asr32(m32, 4);
    if (in_xfer) begin
      raw_r        <= in_data.raw_reading;
      res_r.kind   <= in_data.func;
      res_r.value  <= 32'd0;
      res_r.div_zero <= 1'b0;
      if (in_data.func == FUNC_HUM) x_r <= {32'b0, ft_r - 32'd76800};
      else                          x_r <= {{32{ft_r[31]}}, ft_r} - 64'd128000;
    end else if (step_done) begin
      unique case (state_r)
        ST_TA: x_r <= {32'b0, asr32(m32, 11)};
        ST_TB: y_r <= {32'b0, asr32(m32, 12)};
        ST_TC: res_r.value <= asr32(ftn + (ftn << 2) + 32'd128, 8);
        ST_PA: y_r <= m;
        ST_PB: z_r <= m;
        ST_PC: z_r <= z_r + (m << 17) + (p4 << 35);
        ST_PD: y_r <= asr64(m, 8);
        ST_PE: y_r <= y_r + (m << 12);
        ST_PF: begin
          y_r <= asr64(m, 33);
          if (asr64(m, 33) == 64'd0) res_r.div_zero <= 1'b1;
        end
        ST_PG:   x_r <= m;
        ST_PDIV: x_r <= quot;
        ST_PI:   z_r <= m;
        ST_PJ:   z_r <= asr64(m, 25);
        ST_PK:   res_r.value <= 32'(asr64(x_r + z_r + asr64(m, 19), 8) + (p7 << 4));
        ST_HA: y_r <= {32'b0, asr32(({12'b0, raw_r} << 14) - (h4[31:0] << 20)
                                    - m32 + 32'd16384, 15)};
        ST_HB: z_r <= {32'b0, asr32(m32, 10)};
        ST_HC: w_r <= {32'b0, asr32(m32, 11) + 32'd32768};
        ST_HD: z_r <= {32'b0, asr32(m32, 10) + 32'd2097152};
        ST_HE: z_r <= {32'b0, asr32(m32 + 32'd8192, 14)};
        ST_HF: x_r <= {32'b0, m32};
        ST_HG: z_r <= {32'b0, asr32(m32, 7)};
        ST_HH: begin
          if (hv[31])            res_r.value <= 32'd0;
          else if (hv > HUM_MAX) res_r.value <= HUM_MAX >> 12;
          else                   res_r.value <= hv >> 12;
        end
        default: ;
      endcase
    end
    if (state_r == ST_DONE && out_free) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a unit is only launched when no step is outstanding
  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_start || div_start) |-> !busy_r)
    else $error("unit launched while a step is outstanding");

  // no step may be outstanding once the sequencer is back at rest
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !busy_r)
    else $error("sequencer idle with a step outstanding");

  // a zero-divisor result is always a pressure result of value zero
  a_dz_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.div_zero) |->
      (out_data_r.kind == FUNC_PRESS && out_data_r.value == 32'd0))
    else $error("div_zero on a non-pressure or non-zero result");

  // an accepted item always puts the sequencer to work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("accepted transfer left the sequencer idle");

endmodule

// ===== tb/env_sensor_compensation_checker.sv =====
`timescale 1ns / 1ps

module env_sensor_compensation_checker
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                n_fail,
  output int                n_pending
);

  logic [47:0] cal_t;
  logic [63:0] cal_pa, cal_pb;
  logic [15:0] cal_pc;
  logic [31:0] cal_ha;
  logic [39:0] cal_hb;
  logic [31:0] t_fine;
  out_t        expected_q[$];

  function automatic logic [63:0] shr_s64(logic [63:0] v, int n);
    return 64'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] shr_s32(logic [31:0] v, int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] ext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] temp_value(logic [31:0] raw);
    logic [31:0] t1, t2, t3, v1, d, v2;
    t1 = {16'd0, cal_t[15:0]};
    t2 = {{16{cal_t[31]}}, cal_t[31:16]};
    t3 = {{16{cal_t[47]}}, cal_t[47:32]};
    v1 = shr_s32(((raw >> 3) - (t1 << 1)) * t2, 11);
    d = (raw >> 4) - t1;
    v2 = shr_s32(shr_s32(d * d, 12) * t3, 14);
    t_fine = v1 + v2;
    return shr_s32(t_fine * 32'd5 + 32'd128, 8);
  endfunction

  function automatic logic [31:0] press_value(logic [31:0] raw, output logic dz);
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, an, ad, q, num;
    p1 = {48'd0, cal_pa[15:0]};
    p2 = ext16(cal_pa[31:16]); p3 = ext16(cal_pa[47:32]); p4 = ext16(cal_pa[63:48]);
    p5 = ext16(cal_pb[15:0]);  p6 = ext16(cal_pb[31:16]);
    p7 = ext16(cal_pb[47:32]); p8 = ext16(cal_pb[63:48]);
    p9 = ext16(cal_pc);
    dz = 1'b0;
    v1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = shr_s64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = shr_s64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      dz = 1'b1;
      return 32'd0;
    end
    p = 64'd1048576 - {32'd0, raw};
    num = ((p << 31) - v2) * 64'd3125;
    // magnitude division, wraps like a 64-bit signed quotient
    an = num[63] ? -num : num;
    ad = v1[63] ? -v1 : v1;
    q = an / ad;
    p = (num[63] != v1[63]) ? -q : q;
    v1 = shr_s64(p9 * shr_s64(p, 13) * shr_s64(p, 13), 25);
    v2 = shr_s64(p8 * p, 19);
    p = shr_s64(p + v1 + v2, 8) + (p7 << 4);
    return p[31:0];
  endfunction

  function automatic logic [31:0] hum_value(logic [31:0] raw);
    logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, s;
    h1 = {24'd0, cal_ha[7:0]};
    h2 = {{16{cal_ha[23]}}, cal_ha[23:8]};
    h3 = {24'd0, cal_ha[31:24]};
    h4 = {{16{cal_hb[15]}}, cal_hb[15:0]};
    h5 = {{16{cal_hb[31]}}, cal_hb[31:16]};
    h6 = {{24{cal_hb[39]}}, cal_hb[39:32]};
    x = t_fine - 32'd76800;
    a = shr_s32((raw << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    b = shr_s32(x * h6, 10) * (shr_s32(x * h3, 11) + 32'd32768);
    b = shr_s32(b, 10) + 32'd2097152;
    b = shr_s32(b * h2 + 32'd8192, 14);
    x = a * b;
    s = shr_s32(x, 15);
    x = x - shr_s32(shr_s32(s * s, 7) * h1, 4);
    if (x[31]) x = 32'd0;
    else if (x > HUM_MAX) x = HUM_MAX;
    return x >> 12;
  endfunction

  always_ff @(posedge clk) begin
    out_t exp_r;
    logic dz;
    if (!rst_n) begin
      cal_t <= '0; cal_pa <= '0; cal_pb <= '0; cal_pc <= '0;
      cal_ha <= '0; cal_hb <= '0; t_fine = '0;
      expected_q.delete();
      n_fail <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEMP:    cal_t  <= cfg_wdata[47:0];
          CFG_PRESS_A: cal_pa <= cfg_wdata;
          CFG_PRESS_B: cal_pb <= cfg_wdata;
          CFG_PRESS_C: cal_pc <= cfg_wdata[15:0];
          CFG_HUM_A:   cal_ha <= cfg_wdata[31:0];
          CFG_HUM_B:   cal_hb <= cfg_wdata[39:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          n_fail <= n_fail + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind !== out_data.kind || exp_r.value !== out_data.value
              || exp_r.div_zero !== out_data.div_zero) begin
            $display("%0t: mismatch expected kind %0d value %h dz %b, actual kind %0d value %h dz %b",
                     $time, exp_r.kind, exp_r.value, exp_r.div_zero,
                     out_data.kind, out_data.value, out_data.div_zero);
            n_fail <= n_fail + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_r.kind = in_data.func;
        exp_r.value = '0;
        exp_r.div_zero = 1'b0;
        case (in_data.func)
          FUNC_TEMP:  exp_r.value = temp_value({12'd0, in_data.raw_reading});
          FUNC_PRESS: begin
            exp_r.value = press_value({12'd0, in_data.raw_reading}, dz);
            exp_r.div_zero = dz;
          end
          FUNC_HUM:   exp_r.value = hum_value({12'd0, in_data.raw_reading});
          default: ;
        endcase
        expected_q.push_back(exp_r);
      end
    end
  end

  assign n_pending = expected_q.size();

endmodule

// ===== tb/env_sensor_compensation_top_test.sv =====
`timescale 1ns / 1ps

module env_sensor_compensation_top_test;
  import esc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_TEMP;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  int                n_fail;
  int                n_pending;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                quiet_cycles = 0;

  // watchdog: long enough for a pressure item, and stalls stretch the hand-back
  localparam int QUIET_LIMIT = 20000;

  always #10 clk = ~clk;

  env_sensor_compensation_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  env_sensor_compensation_checker i_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .n_fail, .n_pending
  );

  // receiver stall, redrawn each cycle at the phase's rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one transfer, with a random gap first at the sender's idle rate;
  // valid stays up so the next transfer can follow straight on
  task automatic send_reading(logic [1:0] f, logic [19:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, raw_reading: raw};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for every result, then let a stray item finish before writing
  task automatic drain();
    in_valid <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cal(cfg_idx_t idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_all(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                          logic [63:0] pc, logic [63:0] ha, logic [63:0] hb);
    write_cal(CFG_TEMP, t);
    write_cal(CFG_PRESS_A, pa);
    write_cal(CFG_PRESS_B, pb);
    write_cal(CFG_PRESS_C, pc);
    write_cal(CFG_HUM_A, ha);
    write_cal(CFG_HUM_B, hb);
  endtask

  // typical factory set, randomised around it with a few bits flipped
  task automatic load_typical(bit jitter);
    logic [63:0] m;
    m = jitter ? {$urandom(), $urandom()} & {$urandom(), $urandom()} & 64'h00ff_00ff_00ff_00ff
               : 64'd0;
    load_all(64'({16'd50, 16'd26435, 16'd27504} ^ m[47:0]),
             {16'd2855, 16'd3024, 16'hd0d3, 16'd36477} ^ m,
             {16'hc0f8, 16'd15500, 16'hfff9, 16'd140} ^ m,
             64'(16'd6000 ^ m[15:0]),
             64'({8'd0, 16'd366, 8'd75} ^ m[31:0]),
             64'({8'd30, 16'd50, 16'd312} ^ m[39:0]));
  endtask

  task automatic random_phase(int n, int idle, int stall);
    int k;
    logic [1:0] f;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (k = 0; k < n; k++) begin
      // func drawn at random among temperature, pressure and humidity, one in twenty unused
      f = ($urandom_range(19) == 0) ? FUNC_UNUSED : 2'($urandom_range(2));
      send_reading(f, 20'($urandom()));
    end
  endtask

  initial begin
    int j;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero calibration gives a zero pressure divisor
    send_reading(FUNC_PRESS, 20'd0);
    send_reading(FUNC_HUM, 20'hfffff);
    send_reading(FUNC_TEMP, 20'd0);
    send_reading(FUNC_UNUSED, 20'hfffff);
    drain();

    load_typical(1'b0);
    send_reading(FUNC_TEMP, 20'd519888);
    send_reading(FUNC_PRESS, 20'd415148);
    send_reading(FUNC_HUM, 20'd30000);
    send_reading(FUNC_TEMP, 20'hfffff);
    send_reading(FUNC_PRESS, 20'hfffff);
    send_reading(FUNC_HUM, 20'hfffff);
    send_reading(FUNC_TEMP, 20'd0);
    send_reading(FUNC_PRESS, 20'd0);
    send_reading(FUNC_HUM, 20'd0);
    send_reading(FUNC_UNUSED, 20'h55555);
    drain();

    // extremes: all ones and sign-bit-only fields; overflow and clamping
    load_all('1, '1, '1, '1, '1, '1);
    for (j = 0; j < 3; j++) send_reading(2'(j), 20'hfffff);
    for (j = 0; j < 3; j++) send_reading(2'(j), 20'd0);
    drain();
    load_all(64'h8000_8000_8000, 64'h8000_8000_8000_ffff, 64'h8000_8000_8000_8000,
             64'h8000, 64'hff80_00ff, 64'h80_8000_8000);
    for (j = 0; j < 3; j++) send_reading(2'(j), 20'h80000);
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    load_typical(1'b1);
    random_phase(150, 0, 0);
    drain();
    load_typical(1'b1);
    random_phase(150, 86, 0);
    // sender holds off until every result has come back
    in_valid <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    random_phase(100, 0, 86);
    drain();
    load_all({$urandom(), $urandom()}, {$urandom(), $urandom()},
             {$urandom(), $urandom()}, {$urandom(), $urandom()},
             {$urandom(), $urandom()}, {$urandom(), $urandom()});
    random_phase(150, 7, 7);
    drain();
    load_typical(1'b1);
    for (j = 0; j < 4; j++) random_phase(50, (j % 2) ? 86 : 0, (j > 1) ? 86 : 7);
    drain();
    load_typical(1'b0);
    random_phase(150, 0, 0);

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (n_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
